// ===== rtl/abpa_pkg.sv =====
// shared types and constants for the aligned bitmap page allocator
// no dependencies; imported by every module of the block but abpa_ram
package abpa_pkg;

  localparam int ADDR_W  = 40;
  localparam int BYTES_W = 25;
  localparam int LIMIT_W = 13;
  localparam int STAT_W  = 3;
  localparam int IDX_W   = 2;
  localparam int WORD_W  = 64;
  localparam int WORD_LG = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_PAGES = 2'd1;
  localparam logic [IDX_W-1:0] REG_TRIM  = 2'd2;

  // request codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd1;
  localparam logic [STAT_W-1:0] ST_REFUSED = 3'd2;
  localparam logic [STAT_W-1:0] ST_ZERO    = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd4;

  // controller to datapath strobes
  typedef struct packed {
    logic accept;
    logic decode;
    logic rd;
    logic chk;
    logic mwr;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic dec_res;
    logic dec_mark;
    logic chk_found;
    logic chk_fail;
    logic mwr_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/aligned_bitmap_page_allocator.sv =====
// top level of the aligned bitmap page allocator
// depends on abpa_pkg, abpa_ctrl, abpa_dp (which holds abpa_ram)
//
// Request channel: in_valid/in_stall with command, request_bytes, can_block
// and release_handle. Result channel: out_valid/out_stall with status and
// handle, one result word per request word, in order.
// Configuration: cfg_write_enable, cfg_index, cfg_data; write only while idle.
// Index 0 base_address, 1 region_pages (reloads the limit), 2 trim_enable.
// The page map sits in a ram of 64-bit rows; a per-row valid bit makes an
// unwritten row read as free, so reset needs no clearing pass.
// An immediate reject goes from decode straight to the finish state. An
// allocate scans the map with a read and a check per row and per retry
// after a used page, then marks each row of the run with a read and a
// write. A free clears each row with a read and a write, then finishes.
// The read-check loop over the map ram sets the rate.
// One request is in flight; in_stall is high from accept until the result is
// placed in the output register. A stalled result holds; the next request may
// be accepted and worked while it waits, and its result waits in turn.
// Reset returns all pages free, the limit to 4096 pages and trimming off.
module aligned_bitmap_page_allocator
  import abpa_pkg::*;
#(
  parameter int MAX_PAGES       = 4096,
  parameter int PAGE_BITS       = 12,
  parameter int MAX_ALIGN_ORDER = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_enable,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [BYTES_W-1:0] request_bytes,
  input  logic               can_block,
  input  logic [ADDR_W-1:0]  release_handle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic [ADDR_W-1:0]  handle
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing
  abpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // map, registers and arithmetic
  abpa_dp #(
    .MAX_PAGES       (MAX_PAGES),
    .PAGE_BITS       (PAGE_BITS),
    .MAX_ALIGN_ORDER (MAX_ALIGN_ORDER)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .command          (command),
    .request_bytes    (request_bytes),
    .can_block        (can_block),
    .release_handle   (release_handle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .handle           (handle),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

// ===== rtl/abpa_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module abpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/abpa_ctrl.sv =====
// controller state machine of the page allocator
// depends on abpa_pkg for the command and status structs
module abpa_ctrl
  import abpa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_RD   = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_MRD  = 7'b0010000,
    S_MWR  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DEC;
      S_DEC: begin
        if (sts.dec_res) state_next = S_FIN;
        else if (sts.dec_mark) state_next = S_MRD;
        else state_next = S_RD;
      end
      S_RD: state_next = S_CHK;
      S_CHK: begin
        if (sts.chk_fail) state_next = S_FIN;
        else if (sts.chk_found) state_next = S_MRD;
        else state_next = S_RD;
      end
      S_MRD: state_next = S_MWR;
      // read the next row before it is written
      S_MWR: begin
        if (sts.mwr_last) state_next = S_FIN;
        else state_next = S_MRD;
      end
      S_FIN: if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // strobes to the datapath
  assign in_stall     = (state != S_IDLE);
  assign cmd.accept   = (state == S_IDLE) && in_valid;
  assign cmd.decode   = (state == S_DEC);
  assign cmd.rd       = (state == S_RD) || (state == S_MRD);
  assign cmd.chk      = (state == S_CHK);
  assign cmd.mwr      = (state == S_MWR);
  assign cmd.out_load = (state == S_FIN) && sts.out_free;

endmodule

// ===== rtl/abpa_dp.sv =====
// datapath: registers, page map ram, scan and mark logic
// depends on abpa_pkg and abpa_ram
module abpa_dp
  import abpa_pkg::*;
#(
  parameter int MAX_PAGES       = 4096,
  parameter int PAGE_BITS       = 12,
  parameter int MAX_ALIGN_ORDER = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_enable,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data,
  input  logic               command,
  input  logic [BYTES_W-1:0] request_bytes,
  input  logic               can_block,
  input  logic [ADDR_W-1:0]  release_handle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic [ADDR_W-1:0]  handle,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts
);

  localparam int ROWS = MAX_PAGES / WORD_W;
  localparam int RW   = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int PW   = $clog2(MAX_PAGES) + 1;
  localparam int CW   = BYTES_W + 1 - PAGE_BITS;
  localparam int MW   = (PW > CW) ? PW : CW;
  localparam int AW   = ((MW > LIMIT_W) ? MW : LIMIT_W) + 2;
  localparam int FW   = ADDR_W - PAGE_BITS;
  localparam int HW   = AW - WORD_LG;
  localparam logic [AW-1:0] AMASK = AW'((64'd1 << MAX_ALIGN_ORDER) - 64'd1);
  localparam logic [AW-1:0] MAXP  = AW'(MAX_PAGES);

  // bits lo..hi of a map word
  function automatic logic [WORD_W-1:0] range_mask(logic [WORD_LG-1:0] lo,
                                                   logic [WORD_LG-1:0] hi);
    logic [WORD_W-1:0] ones;
    ones = '1;
    return (ones << lo) & (ones >> (WORD_LG'(WORD_W - 1) - hi));
  endfunction

  // configuration and state
  logic [ADDR_W-1:0]  base;
  logic [LIMIT_W-1:0] region_limit;
  logic               trim_pending;

  // request registers
  logic              cmd_q, can_q, zero_q;
  logic [AW-1:0]     cnt, cm1, amask;
  logic [ADDR_W:0]   diff;
  logic [AW-1:0]     cand, p, endp;
  logic [STAT_W-1:0] res_status;
  logic [ADDR_W-1:0] res_handle;
  logic [ROWS-1:0]   row_vld;
  logic              rvld_q;
  logic [WORD_W-1:0] rdata, dat, wdata;

  // size to pages and alignment mask of the incoming word
  logic [BYTES_W:0] bytes_up;
  logic [CW-1:0]    cnt_in, sm;
  always_comb begin
    bytes_up = {1'b0, request_bytes} + (BYTES_W+1)'((64'd1 << PAGE_BITS) - 64'd1);
    cnt_in   = bytes_up[PAGE_BITS +: CW];
    sm       = cnt_in - CW'(1);
    sm       = sm | (sm >> 1);
    sm       = sm | (sm >> 2);
    sm       = sm | (sm >> 4);
    sm       = sm | (sm >> 8);
    sm       = sm | (sm >> 16);
  end

  // usable pages: the region limit, capped at MAX_PAGES
  logic [AW-1:0] lim;
  assign lim = (AW'(region_limit) < MAXP) ? AW'(region_limit) : MAXP;

  // free decode
  logic [FW-1:0] first_w;
  logic [AW-1:0] first_a, last_a;
  logic          first_out;
  assign first_w   = diff[ADDR_W-1:PAGE_BITS];
  assign first_out = diff[ADDR_W] || (first_w >= FW'(lim));
  assign first_a   = AW'(first_w);
  assign last_a    = first_a + cnt;

  // scan of one word
  logic [AW-1:0]     e, xnext, cn;
  logic [WORD_LG-1:0] lo, hi, u;
  logic              same_row;
  logic [WORD_W-1:0] used;
  logic              fail;
  always_comb begin
    dat      = rvld_q ? rdata : '0;
    e        = cand + cm1;
    lo       = p[WORD_LG-1:0];
    same_row = (e[AW-1:WORD_LG] == p[AW-1:WORD_LG]);
    hi       = same_row ? e[WORD_LG-1:0] : '1;
    used     = dat & range_mask(lo, hi);
    u        = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (used[i]) u = WORD_LG'(i);
    end
    xnext = {p[AW-1:WORD_LG], {WORD_LG{1'b0}}} + AW'(u) + AW'(1);
    cn    = (xnext + amask) & ~amask;
    fail  = (cn + cnt) > lim;
  end

  // mark or clear of one word
  logic              same_m;
  logic [WORD_W-1:0] mmask;
  logic [RW-1:0]     row;
  logic [HW-1:0]     row_next;
  assign row      = p[WORD_LG +: RW];
  assign row_next = p[AW-1:WORD_LG] + HW'(1);
  assign same_m   = (endp[AW-1:WORD_LG] == p[AW-1:WORD_LG]);
  assign mmask    = range_mask(p[WORD_LG-1:0], same_m ? endp[WORD_LG-1:0] : '1);
  assign wdata    = (cmd_q == CMD_FREE) ? (dat & ~mmask) : (dat | mmask);

  abpa_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_map (
    .clk   (clk),
    .we    (cmd.mwr),
    .waddr (row),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (row),
    .rdata (rdata)
  );

  // status to the controller
  assign sts.dec_res   = (cmd_q == CMD_ALLOC) ? (!can_q || zero_q || cnt > lim)
                                             : (zero_q || first_out);
  assign sts.dec_mark  = (cmd_q == CMD_FREE);
  assign sts.chk_found = (used == '0) && same_row;
  assign sts.chk_fail  = (used != '0) && fail;
  assign sts.mwr_last  = same_m;
  assign sts.out_free  = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base         <= '0;
      region_limit <= LIMIT_RESET;
      trim_pending <= 1'b0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_BASE:  base <= cfg_data;
        REG_PAGES: region_limit <= cfg_data[LIMIT_W-1:0];
        REG_TRIM:  trim_pending <= cfg_data[0];
        default: ;
      endcase
    end else if (cmd.mwr && same_m && cmd_q == CMD_ALLOC && trim_pending) begin
      region_limit <= LIMIT_W'(cand + cnt);
      trim_pending <= 1'b0;
    end
  end

  // row valid bits: a row never written reads as all free
  always_ff @(posedge clk) begin
    if (rst) row_vld <= '0;
    else if (cmd.mwr) row_vld[row] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rvld_q <= row_vld[row];
  end

  // request capture, scan and mark pointers, result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q  <= command;
      can_q  <= can_block;
      zero_q <= (request_bytes == '0);
      cnt    <= AW'(cnt_in);
      cm1    <= AW'(cnt_in) - AW'(1);
      amask  <= AW'(sm) & AMASK;
      diff   <= {1'b0, release_handle} - {1'b0, base};
    end
    if (cmd.decode) begin
      res_handle <= '0;
      if (cmd_q == CMD_ALLOC) begin
        cand <= '0;
        p    <= '0;
        if (!can_q) res_status <= ST_REFUSED;
        else if (zero_q) res_status <= ST_ZERO;
        else res_status <= ST_NOSPACE;
      end else begin
        p    <= first_a;
        endp <= ((last_a > lim) ? lim : last_a) - AW'(1);
        if (zero_q) res_status <= ST_ZERO;
        else res_status <= ST_RANGE;
      end
    end
    if (cmd.chk) begin
      if (used == '0) begin
        if (same_row) begin
          p    <= cand;
          endp <= e;
        end else begin
          p <= {row_next, {WORD_LG{1'b0}}};
        end
      end else if (!fail) begin
        cand <= cn;
        p    <= cn;
      end else begin
        res_status <= ST_NOSPACE;
        res_handle <= '0;
      end
    end
    if (cmd.mwr) begin
      if (same_m) begin
        res_status <= ST_OK;
        res_handle <= (cmd_q == CMD_ALLOC) ? base + (ADDR_W'(cand) << PAGE_BITS) : '0;
      end else begin
        p <= {row_next, {WORD_LG{1'b0}}};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= res_status;
      handle <= res_handle;
    end
  end

  // checks
  a_found_in_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.chk && sts.chk_found |-> (cand + cnt) <= lim)
    else $error("allocated run passes the page limit");

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    cmd.chk && cmd_q == CMD_ALLOC |-> p >= cand)
    else $error("scan pointer behind candidate start");

  a_mark_range: assert property (@(posedge clk) disable iff (rst)
    cmd.mwr |-> p <= endp)
    else $error("mark pointer past run end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || !out_stall)
    else $error("result loaded over a waiting word");

endmodule

// ===== verif/abpa_checker.sv =====
// scoreboard for the aligned bitmap page allocator: watches config writes and
// both word channels, predicts each result and compares it; depends on abpa_pkg
module abpa_checker
  import abpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_enable,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               command,
  input  logic [BYTES_W-1:0] request_bytes,
  input  logic               can_block,
  input  logic [ADDR_W-1:0]  release_handle,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [STAT_W-1:0]  status,
  input  logic [ADDR_W-1:0]  handle,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPAGES = 4096;
  localparam int PGBITS = 12;
  localparam int ALIGN_CAP = 8;

  typedef struct packed {
    logic [STAT_W-1:0] st;
    logic [ADDR_W-1:0] addr;
  } outcome_t;

  // model copy of the allocator state and registers
  logic [ADDR_W-1:0]  base_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               trim_q;
  bit                 page_used [NPAGES];
  outcome_t           outcome_q[$];

  function automatic int usable_pages();
    return (int'(limit_q) < NPAGES) ? int'(limit_q) : NPAGES;
  endfunction

  function automatic int bytes_in_pages(logic [BYTES_W-1:0] b);
    return int'((longint'(b) + (1 << PGBITS) - 1) >> PGBITS);
  endfunction

  // lowest aligned free run, marked used
  function automatic outcome_t predict_allocation(logic [BYTES_W-1:0] b, logic cb);
    int lim, cnt, ord, step, s;
    bit clear;
    outcome_t r;
    r.st = ST_NOSPACE;
    r.addr = '0;
    if (!cb) begin
      r.st = ST_REFUSED;
      return r;
    end
    if (b == 0) begin
      r.st = ST_ZERO;
      return r;
    end
    lim = usable_pages();
    cnt = bytes_in_pages(b);
    ord = 0;
    while (ord < 31 && (1 << ord) < cnt) ord++;
    if (ord > ALIGN_CAP) ord = ALIGN_CAP;
    step = 1 << ord;
    for (s = 0; cnt <= lim && s <= lim - cnt; s += step) begin
      clear = 1;
      for (int i = 0; i < cnt; i++)
        if (page_used[s + i]) begin
          clear = 0;
          break;
        end
      if (clear) begin
        for (int i = 0; i < cnt; i++) page_used[s + i] = 1;
        if (trim_q) begin
          limit_q = LIMIT_W'(s + cnt);
          trim_q = 0;
        end
        r.st = ST_OK;
        r.addr = base_q + (ADDR_W'(s) << PGBITS);
        return r;
      end
    end
    return r;
  endfunction

  // clear the named pages, stopping at the usable limit
  function automatic outcome_t predict_release(logic [BYTES_W-1:0] b,
                                               logic [ADDR_W-1:0] h);
    int lim;
    longint first, last;
    outcome_t r;
    r.st = ST_OK;
    r.addr = '0;
    lim = usable_pages();
    if (b == 0) begin
      r.st = ST_ZERO;
      return r;
    end
    if (h < base_q) begin
      r.st = ST_RANGE;
      return r;
    end
    first = longint'(h - base_q) >> PGBITS;
    if (first >= lim) begin
      r.st = ST_RANGE;
      return r;
    end
    last = first + bytes_in_pages(b);
    if (last > lim) last = lim;
    for (longint p = first; p < last; p++) page_used[p] = 0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                 logic [ADDR_W-1:0] want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      base_q = '0;
      limit_q = LIMIT_RESET;
      trim_q = 0;
      foreach (page_used[i]) page_used[i] = 0;
      outcome_q.delete();
      fail_count = 0;
    end else begin
      // register writes
      if (cfg_write_enable) begin
        case (cfg_index)
          REG_BASE: base_q = cfg_data;
          REG_PAGES: limit_q = cfg_data[LIMIT_W-1:0];
          REG_TRIM: trim_q = cfg_data[0];
          default: ;
        endcase
      end
      // accepted request word
      if (in_valid && !in_stall) begin
        if (command == CMD_ALLOC) outcome_q.push_back(predict_allocation(request_bytes, can_block));
        else outcome_q.push_back(predict_release(request_bytes, release_handle));
      end
      // accepted result word
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result, status", ADDR_W'(status), '0);
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.st) report_mismatch("status", ADDR_W'(status), ADDR_W'(want.st));
          if (handle !== want.addr) report_mismatch("handle", handle, want.addr);
        end
      end
    end
    pending = outcome_q.size();
  end

endmodule

// ===== verif/tb_aligned_bitmap_page_allocator.sv =====
// top of the aligned bitmap page allocator testbench: clock, reset, stimulus
// and verdict; depends on abpa_pkg, abpa_checker and the allocator rtl
module tb_aligned_bitmap_page_allocator
  import abpa_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1880;
  localparam longint CYCLE_LIMIT = 60000000;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_write_enable = 0;
  logic [IDX_W-1:0]   cfg_index = REG_BASE;
  logic [ADDR_W-1:0]  cfg_data = '0;
  logic               in_valid = 0;
  logic               in_stall;
  logic               command = CMD_ALLOC;
  logic [BYTES_W-1:0] request_bytes = '0;
  logic               can_block = 0;
  logic [ADDR_W-1:0]  release_handle = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [STAT_W-1:0]  status;
  logic [ADDR_W-1:0]  handle;
  int                 fail_count;
  int                 pending;

  // stimulus knobs
  bit                 idle_on = 1;
  bit                 hold_req = 0;
  logic [ADDR_W-1:0]  cur_base = '0;
  int                 cur_pages = 4096;
  longint             cycles = 0;

  aligned_bitmap_page_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .request_bytes(request_bytes), .can_block(can_block), .release_handle(release_handle),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .handle(handle)
  );

  abpa_checker scoreboard (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .request_bytes(request_bytes), .can_block(can_block), .release_handle(release_handle),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .handle(handle),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("aligned_bitmap_page_allocator test failed");
      $finish;
    end
  end

  // result side: idle bursts and one long hold-off
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        out_stall <= 0;
        hold_req = 0;
        @(posedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // offer one request word and wait for it to be taken
  task automatic send_word(logic cmd, logic [BYTES_W-1:0] nbytes, logic cb,
                           logic [ADDR_W-1:0] rh);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    request_bytes <= nbytes;
    can_block <= cb;
    release_handle <= rh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    cfg_write_enable <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_enable <= 0;
    @(posedge clk);
  endtask

  task automatic configure(logic [ADDR_W-1:0] b, int npages, logic trim);
    drain();
    repeat (10) @(posedge clk);
    write_reg(REG_BASE, b);
    write_reg(REG_PAGES, ADDR_W'(npages));
    write_reg(REG_TRIM, ADDR_W'(trim));
    cur_base = b;
    cur_pages = (npages < 4096) ? npages : 4096;
  endtask

  // mostly aligned allocate/free traffic over the region, some noise
  task automatic random_word();
    int r, npg, pg;
    logic [BYTES_W-1:0] nb;
    logic [ADDR_W-1:0] h;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) npg = $urandom_range(1, 4096);
    else npg = $urandom_range(1, 8);
    nb = BYTES_W'(npg * 4096 - $urandom_range(0, 4095));
    if (r < 45) begin
      send_word(CMD_ALLOC, nb, 1'b1, ADDR_W'({$urandom, $urandom}));
    end else if (r < 85) begin
      pg = $urandom_range(0, cur_pages);
      h = cur_base + (ADDR_W'(pg) << 12);
      if ($urandom_range(0, 3) == 0) h = h + ADDR_W'($urandom_range(1, 4095));
      send_word(CMD_FREE, nb, 1'($urandom_range(0, 1)), h);
    end else begin
      if ($urandom_range(0, 4) == 0) nb = '0;
      else nb = BYTES_W'($urandom_range(0, 16777216));
      send_word(1'($urandom_range(0, 1)), nb, 1'($urandom_range(0, 1)),
                ADDR_W'({$urandom, $urandom}));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: status codes, alignment, size extremes
    configure(40'h0, 4096, 1'b0);
    send_word(CMD_ALLOC, 25'd0, 1'b0, 40'h0);
    send_word(CMD_ALLOC, 25'd0, 1'b1, 40'h0);
    send_word(CMD_FREE, 25'd0, 1'b1, 40'h0);
    send_word(CMD_ALLOC, 25'd1, 1'b1, 40'h0);
    send_word(CMD_ALLOC, 25'd4097, 1'b1, 40'h0);
    send_word(CMD_ALLOC, 25'd16777216, 1'b1, 40'h0);
    send_word(CMD_ALLOC, 25'd1228800, 1'b1, 40'h0);
    send_word(CMD_FREE, 25'd1, 1'b1, 40'hFF_FFFF_FFFF);
    send_word(CMD_FREE, 25'd1, 1'b0, 40'h2345);
    send_word(CMD_FREE, 25'd16777216, 1'b1, 40'h0);
    send_word(CMD_ALLOC, 25'd16777216, 1'b1, 40'h0);
    send_word(CMD_ALLOC, 25'd4096, 1'b1, 40'h0);
    send_word(CMD_FREE, 25'h1FF_FFFF, 1'b1, 40'h0);

    // limit above map, free below base, trimming on first success
    configure(40'h10000000, 5000, 1'b1);
    send_word(CMD_FREE, 25'd1, 1'b1, 40'h100);
    send_word(CMD_ALLOC, 25'd8192, 1'b1, 40'h0);
    send_word(CMD_ALLOC, 25'd4096, 1'b1, 40'h0);
    send_word(CMD_FREE, 25'd8192, 1'b1, 40'h10000000);

    // handle wraps past the top of the address space
    configure(40'hFF_FFFF_F000, 8191, 1'b0);
    send_word(CMD_ALLOC, 25'd8192, 1'b1, 40'h0);
    send_word(CMD_ALLOC, 25'd4096, 1'b1, 40'h0);
    send_word(CMD_FREE, 25'd16384, 1'b1, 40'hFF_FFFF_F000);

    // single-page region
    configure(40'h5000, 1, 1'b0);
    send_word(CMD_ALLOC, 25'd1, 1'b1, 40'h0);
    send_word(CMD_ALLOC, 25'd1, 1'b1, 40'h0);
    send_word(CMD_FREE, 25'd1, 1'b1, 40'h6000);
    send_word(CMD_FREE, 25'd4096, 1'b1, 40'h5000);

    // random phases over several settings; the last one has no idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: configure(40'h0, 4096, 1'b0);
        1: configure(ADDR_W'($urandom) << 12, 1000, 1'b1);
        2: configure(40'hFF_FFFF_0000, 8191, 1'b0);
        default: configure(40'h7_0000, 64, 1'b1);
      endcase
      idle_on = (ph != 3);
      for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
        if (ph == 0 && n == 100) hold_req = 1;
        if (ph == 1 && n == 200) drain();
        random_word();
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("aligned_bitmap_page_allocator test passed");
    end else begin
      $display("aligned_bitmap_page_allocator test failed");
    end
    $finish;
  end

endmodule

// ===== aligned_bitmap_page_allocator.f =====
rtl/abpa_pkg.sv
rtl/abpa_ram.sv
rtl/abpa_ctrl.sv
rtl/abpa_dp.sv
rtl/aligned_bitmap_page_allocator.sv
verif/abpa_checker.sv
verif/tb_aligned_bitmap_page_allocator.sv
